[rtl/btau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear texel address unit: shared definitions
// Types, constants and stage control shared by the address unit files.
// ----------------------------------------------------------------------------
package btau_pkg;

	localparam int LANES     = 4;
	localparam int LANE_W    = 2;
	localparam int MAX_MIPS  = 16;
	localparam int ADDR_W    = 4;
	localparam int FP_W      = 48;
	localparam int BLEN_W    = 6;

	localparam logic [15:0] LOD_SCALE = 16'd39322;

	localparam logic [1:0] REG_WIDTH_LOG2  = 2'd0;
	localparam logic [1:0] REG_HEIGHT_LOG2 = 2'd1;
	localparam logic [1:0] REG_MIP_COUNT   = 2'd2;

	typedef struct packed {
		logic [31:0] lane0_uv;
		logic [31:0] lane1_uv;
		logic [31:0] lane2_uv;
		logic [31:0] lane3_uv;
		logic [63:0] lane0_footprint;
		logic [63:0] lane1_footprint;
		logic [63:0] lane2_footprint;
		logic [63:0] lane3_footprint;
		logic        use_mips;
	} quad_t;

	typedef struct packed {
		logic [1:0]  lane_index;
		logic [3:0]  mip_level;
		logic [15:0] col_first;
		logic [15:0] col_second;
		logic [15:0] row_first;
		logic [15:0] row_second;
		logic [15:0] frac_x;
		logic [15:0] frac_y;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [15:0] col_first;
		logic [15:0] col_second;
		logic [15:0] row_first;
		logic [15:0] row_second;
		logic [15:0] frac_x;
		logic [15:0] frac_y;
	} lane_res_t;

	typedef struct packed {
		logic [15:0] wmul;
		logic [15:0] hmul;
		logic [16:0] h;
		logic [3:0]  mip_max;
	} cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} adv_t;

endpackage

`default_nettype wire

[rtl/btau_quad_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quad input channel
// Valid/ready channel that carries one quad of coordinates and footprints.
// ----------------------------------------------------------------------------
interface btau_quad_if;
	import btau_pkg::*;

	logic  valid;
	logic  ready;
	quad_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/btau_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lane result channel
// Valid/ready channel that carries one lane's texel addresses and weights.
// ----------------------------------------------------------------------------
interface btau_result_if;
	import btau_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/bilinear_texel_address_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear texel address unit
// Turns a quad of texture coordinates and footprints into per-lane mip
// level, bilinear texel columns and rows, and blend fractions.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer carries
//  quad      in         four packed uv coordinates, four footprints, use_mips
//  result    out        one lane's level, columns, rows and fractions
//  APB       in/out     width_log2 @0x0, height_log2 @0x4, mip_count @0x8
//
//  A quad runs through six pipeline stages into the result serializer, which
//  hands out lanes 0 to 3 one per cycle while the result channel is ready.
//  The single result channel sets the rate: each quad needs four transfers.
//  Each stage advances when the next has room, so a stalled result backs up
//  the pipeline without dropping or repeating work.
//  Reset clears the stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module bilinear_texel_address_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	btau_quad_if.sink                          quad,
	btau_result_if.source                      result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [btau_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import btau_pkg::*;

	logic [4:0] width_log2_q;
	logic [4:0] height_log2_q;
	logic [4:0] mip_count_q;

	logic [4:0]  wl_sat;
	logic [4:0]  hl_sat;
	logic [4:0]  mips_sat;
	logic [16:0] w_full;
	logic [16:0] h_full;
	cfg_t        cfg;

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic vld_s5;
	logic vld_s6;
	adv_t adv;
	logic ser_free;
	logic ser_load;

	logic [LANES-1:0][31:0] uv;
	logic [LANES-1:0][63:0] footprint;
	logic [3:0]             level_s5;
	lane_res_t [LANES-1:0]  lane_res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= 5'd8;
			height_log2_q <= 5'd8;
			mip_count_q   <= 5'd1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_WIDTH_LOG2:  width_log2_q  <= pwdata[4:0];
				REG_HEIGHT_LOG2: height_log2_q <= pwdata[4:0];
				REG_MIP_COUNT:   mip_count_q   <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH_LOG2:  prdata = {27'd0, width_log2_q};
			REG_HEIGHT_LOG2: prdata = {27'd0, height_log2_q};
			REG_MIP_COUNT:   prdata = {27'd0, mip_count_q};
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		wl_sat = (width_log2_q > 5'd16) ? 5'd16 : width_log2_q;
		hl_sat = (height_log2_q > 5'd16) ? 5'd16 : height_log2_q;
		if (mip_count_q == 5'd0) begin
			mips_sat = 5'd1;
		end else if (mip_count_q > 5'(MAX_MIPS)) begin
			mips_sat = 5'(MAX_MIPS);
		end else begin
			mips_sat = mip_count_q;
		end
		w_full      = 17'd1 << wl_sat;
		h_full      = 17'd1 << hl_sat;
		cfg.wmul    = 16'(w_full - 17'd1);
		cfg.hmul    = 16'(h_full - 17'd1);
		cfg.h       = h_full;
		cfg.mip_max = 4'(mips_sat - 5'd1);
	end

	assign adv.s6     = !vld_s6 || ser_free;
	assign adv.s5     = !vld_s5 || adv.s6;
	assign adv.s4     = !vld_s4 || adv.s5;
	assign adv.s3     = !vld_s3 || adv.s4;
	assign adv.s2     = !vld_s2 || adv.s3;
	assign adv.s1     = !vld_s1 || adv.s2;
	assign quad.ready = adv.s1;
	assign ser_load   = vld_s6 && ser_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv.s1) begin
				vld_s1 <= quad.valid;
			end
			if (adv.s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv.s3) begin
				vld_s3 <= vld_s2;
			end
			if (adv.s4) begin
				vld_s4 <= vld_s3;
			end
			if (adv.s5) begin
				vld_s5 <= vld_s4;
			end
			if (adv.s6) begin
				vld_s6 <= vld_s5;
			end
		end
	end

	assign uv[0]        = quad.data.lane0_uv;
	assign uv[1]        = quad.data.lane1_uv;
	assign uv[2]        = quad.data.lane2_uv;
	assign uv[3]        = quad.data.lane3_uv;
	assign footprint[0] = quad.data.lane0_footprint;
	assign footprint[1] = quad.data.lane1_footprint;
	assign footprint[2] = quad.data.lane2_footprint;
	assign footprint[3] = quad.data.lane3_footprint;

	btau_mip_select u_mip (
		.clk      (clk),
		.adv      (adv),
		.cfg      (cfg),
		.footprint(footprint),
		.use_mips (quad.data.use_mips),
		.level_s5 (level_s5)
	);

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		btau_lane_addr u_lane (
			.clk   (clk),
			.adv   (adv),
			.cfg   (cfg),
			.uv    (uv[k]),
			.level (level_s5),
			.res_s6(lane_res[k])
		);
	end

	logic [3:0] level_s6;

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			level_s6 <= level_s5;
		end
	end

	btau_out_ser u_ser (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (ser_load),
		.lanes (lane_res),
		.level (level_s6),
		.free  (ser_free),
		.result(result)
	);

endmodule

`default_nettype wire

[rtl/btau_mip_select.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mip level select
// Scales the quad's footprints, finds the smallest, multiplies by 0.6 and
// takes the bit length of the integer part, clamped to the last level.
// ----------------------------------------------------------------------------
module btau_mip_select (
	input  wire logic                                 clk,
	input  wire btau_pkg::adv_t                       adv,
	input  wire btau_pkg::cfg_t                       cfg,
	input  wire logic [btau_pkg::LANES-1:0][63:0]     footprint,
	input  wire logic                                 use_mips,
	output logic [3:0]                                level_s5
);
	import btau_pkg::*;

	logic [FP_W-1:0] du_s1 [LANES];
	logic [FP_W-1:0] dv_s1 [LANES];
	logic            use_s1;
	logic [FP_W-1:0] t_s2 [LANES];
	logic            use_s2;
	logic [FP_W-1:0] m_s3;
	logic            use_s3;
	logic [47:0]     hi_s4;
	logic [31:0]     lo_s4;
	logic            use_s4;

	logic [FP_W-1:0] m_min;
	logic [48:0]     q_sum;
	logic [32:0]     pix;
	logic [BLEN_W-1:0] blen;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			for (int k = 0; k < LANES; k++) begin
				du_s1[k] <= footprint[k][63:32] * cfg.wmul;
				dv_s1[k] <= footprint[k][31:0] * cfg.hmul;
			end
			use_s1 <= use_mips;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int k = 0; k < LANES; k++) begin
				t_s2[k] <= (du_s1[k] < dv_s1[k]) ? du_s1[k] : dv_s1[k];
			end
			use_s2 <= use_s1;
		end
	end

	always_comb begin
		m_min = t_s2[0];
		for (int k = 1; k < LANES; k++) begin
			if (t_s2[k] < m_min) begin
				m_min = t_s2[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			m_s3   <= m_min;
			use_s3 <= use_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			hi_s4  <= m_s3[47:16] * LOD_SCALE;
			lo_s4  <= m_s3[15:0] * LOD_SCALE;
			use_s4 <= use_s3;
		end
	end

	assign q_sum = {1'b0, hi_s4} + 49'(lo_s4[31:16]);
	assign pix   = q_sum[48:16];

	always_comb begin
		blen = '0;
		for (int i = 0; i < 33; i++) begin
			if (pix[i]) begin
				blen = BLEN_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			if (!use_s4) begin
				level_s5 <= '0;
			end else if (blen > {2'b00, cfg.mip_max}) begin
				level_s5 <= cfg.mip_max;
			end else begin
				level_s5 <= blen[3:0];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/btau_lane_addr.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lane address path
// Scales one lane's coordinate to texel space, carries it alongside the mip
// select, then shifts and masks columns and flipped rows for the level.
// ----------------------------------------------------------------------------
module btau_lane_addr (
	input  wire logic                clk,
	input  wire btau_pkg::adv_t      adv,
	input  wire btau_pkg::cfg_t      cfg,
	input  wire logic [31:0]         uv,
	input  wire logic [3:0]          level,
	output btau_pkg::lane_res_t      res_s6
);
	import btau_pkg::*;

	logic [63:0] pp_s1;
	logic [63:0] pp_s2;
	logic [63:0] pp_s3;
	logic [63:0] pp_s4;
	logic [63:0] pp_s5;

	logic [15:0] x1;
	logic [15:0] y1;
	logic [16:0] x2;
	logic [16:0] r1;
	logic [16:0] r2;
	logic [15:0] wm;
	logic [15:0] hm;
	logic [16:0] c1_sh;
	logic [16:0] c2_sh;
	logic [16:0] r1_sh;
	logic [16:0] r2_sh;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			pp_s1 <= {32'(uv[31:16]) * 32'(cfg.wmul), 32'(uv[15:0]) * 32'(cfg.hmul)};
		end
		if (adv.s2) begin
			pp_s2 <= pp_s1;
		end
		if (adv.s3) begin
			pp_s3 <= pp_s2;
		end
		if (adv.s4) begin
			pp_s4 <= pp_s3;
		end
		if (adv.s5) begin
			pp_s5 <= pp_s4;
		end
	end

	assign x1    = pp_s5[63:48];
	assign y1    = pp_s5[31:16];
	assign x2    = {1'b0, x1} + 17'd1;
	assign r1    = cfg.h - {1'b0, y1};
	assign r2    = r1 - 17'd1;
	assign wm    = cfg.wmul >> level;
	assign hm    = cfg.hmul >> level;
	assign c1_sh = {1'b0, x1} >> level;
	assign c2_sh = x2 >> level;
	assign r1_sh = r1 >> level;
	assign r2_sh = r2 >> level;

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			res_s6.col_first  <= c1_sh[15:0] & wm;
			res_s6.col_second <= c2_sh[15:0] & wm;
			res_s6.row_first  <= r1_sh[15:0] & hm;
			res_s6.row_second <= r2_sh[15:0] & hm;
			res_s6.frac_x     <= pp_s5[47:32];
			res_s6.frac_y     <= pp_s5[15:0];
		end
	end

endmodule

`default_nettype wire

[rtl/btau_out_ser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result serializer
// Holds one finished quad and hands out its lane results one per transfer.
// ----------------------------------------------------------------------------
module btau_out_ser (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 load,
	input  wire btau_pkg::lane_res_t [btau_pkg::LANES-1:0] lanes,
	input  wire logic [3:0]                           level,
	output logic                                      free,
	btau_result_if.source                             result
);
	import btau_pkg::*;

	lane_res_t         hold_q [LANES];
	logic [3:0]        level_q;
	logic [LANE_W-1:0] lane_q;
	logic              valid_q;
	logic              at_last;
	logic              xfer;

	assign at_last = (lane_q == LANE_W'(LANES - 1));
	assign xfer    = valid_q && result.ready;
	assign free    = !valid_q || (xfer && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lane_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			lane_q  <= '0;
		end else if (xfer) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end else begin
				lane_q <= lane_q + LANE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < LANES; k++) begin
				hold_q[k] <= lanes[k];
			end
			level_q <= level;
		end
	end

	assign result.valid           = valid_q;
	assign result.data.lane_index = 2'(lane_q);
	assign result.data.mip_level  = level_q;
	assign result.data.col_first  = hold_q[lane_q].col_first;
	assign result.data.col_second = hold_q[lane_q].col_second;
	assign result.data.row_first  = hold_q[lane_q].row_first;
	assign result.data.row_second = hold_q[lane_q].row_second;
	assign result.data.frac_x     = hold_q[lane_q].frac_x;
	assign result.data.frac_y     = hold_q[lane_q].frac_y;
	assign result.data.last       = at_last;

endmodule

`default_nettype wire

[rtl/btau_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel checker
// Watches the result port for lane order and a stable level within a quad.
// ----------------------------------------------------------------------------
module btau_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       res_valid,
	input  wire logic       res_ready,
	input  wire logic [1:0] res_lane,
	input  wire logic [3:0] res_level,
	input  wire logic       res_last
);
	logic res_xfer;

	assign res_xfer = res_valid && res_ready;

	a_last_on_lane3 : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_last == (res_lane == 2'd3)))
		else $error("last flag does not match the final lane");

	a_lane_steps : assert property (@(posedge clk) disable iff (!arst_n)
		(res_xfer && !res_last) |=> (res_valid && res_lane == 2'($past(res_lane) + 2'd1)))
		else $error("lane results of a quad are not consecutive");

	a_level_held : assert property (@(posedge clk) disable iff (!arst_n)
		(res_xfer && !res_last) |=> (res_level == $past(res_level)))
		else $error("mip level changed within a quad");

	a_quad_starts_lane0 : assert property (@(posedge clk) disable iff (!arst_n)
		(res_xfer && res_last) |=> (!res_valid || res_lane == 2'd0))
		else $error("a new quad does not start at lane 0");

endmodule

bind bilinear_texel_address_unit btau_checker u_btau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_lane (result.data.lane_index),
	.res_level(result.data.mip_level),
	.res_last (result.data.last)
);

`default_nettype wire

[bench/bilinear_texel_address_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texel address unit testbench
// Sends quads of texture coordinates and footprints under several texture
// sizes and mip counts, predicts the four lane results of every quad, and
// checks each result transfer field by field in arrival order. Both channels
// idle at random, and one test holds the result channel off long enough for
// the block to fill up and stall its input. Register writes are read back.
// ----------------------------------------------------------------------------
module bilinear_texel_address_unit_test;
	import btau_pkg::*;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          REPORT_LIMIT  = 10;
	localparam int          DRAIN_CYCLES  = 16;
	localparam int          HOLD_CYCLES   = 200;
	localparam logic [63:0] LOD_MUL       = 64'd39322;
	localparam logic [1:0]  REG_UNUSED    = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	btau_quad_if   quad_bus ();
	btau_result_if result_bus ();

	bilinear_texel_address_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.quad    (quad_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [4:0] cfg_width_log2;
	logic [4:0] cfg_height_log2;
	logic [4:0] cfg_mip_count;

	result_t texel_addr_q [$];
	int      error_count;
	int      cycle_count;
	bit      sender_pauses;
	bit      receiver_pauses;
	int      hold_off_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	function automatic void compute_texel_addresses(input quad_t q);
		logic [31:0] uvs [4];
		logic [63:0] fps [4];
		logic [63:0] w, h, wmul, hmul, du, dv, t, m, scaled, pix;
		logic [63:0] px, py, x1, y1, x2, r1, r2, wm, hm;
		int          wl, hl, mips, level;
		result_t     r;
		uvs[0] = q.lane0_uv;
		uvs[1] = q.lane1_uv;
		uvs[2] = q.lane2_uv;
		uvs[3] = q.lane3_uv;
		fps[0] = q.lane0_footprint;
		fps[1] = q.lane1_footprint;
		fps[2] = q.lane2_footprint;
		fps[3] = q.lane3_footprint;
		wl = (cfg_width_log2 > 5'd16) ? 16 : int'(cfg_width_log2);
		hl = (cfg_height_log2 > 5'd16) ? 16 : int'(cfg_height_log2);
		w = 64'd1 << wl;
		h = 64'd1 << hl;
		wmul = w - 64'd1;
		hmul = h - 64'd1;
		mips = int'(cfg_mip_count);
		if (mips < 1)
			mips = 1;
		if (mips > MAX_MIPS)
			mips = MAX_MIPS;
		level = 0;
		if (q.use_mips) begin
			m = '1;
			for (int k = 0; k < 4; k++) begin
				du = {32'd0, fps[k][63:32]} * wmul;
				dv = {32'd0, fps[k][31:0]} * hmul;
				t = (du < dv) ? du : dv;
				if (t < m)
					m = t;
			end
			scaled = (m >> 16) * LOD_MUL + (((m & 64'hFFFF) * LOD_MUL) >> 16);
			pix = scaled >> 16;
			while (pix != 64'd0) begin
				level++;
				pix = pix >> 1;
			end
			if (level > mips - 1)
				level = mips - 1;
		end
		for (int k = 0; k < 4; k++) begin
			px = {48'd0, uvs[k][31:16]} * wmul;
			py = {48'd0, uvs[k][15:0]} * hmul;
			x1 = px >> 16;
			y1 = py >> 16;
			x2 = x1 + 64'd1;
			r1 = h - y1;
			r2 = h - y1 - 64'd1;
			wm = wmul >> level;
			hm = hmul >> level;
			r.lane_index = 2'(k);
			r.mip_level  = 4'(level);
			r.col_first  = 16'((x1 >> level) & wm);
			r.col_second = 16'((x2 >> level) & wm);
			r.row_first  = 16'((r1 >> level) & hm);
			r.row_second = 16'((r2 >> level) & hm);
			r.frac_x     = px[15:0];
			r.frac_y     = py[15:0];
			r.last       = (k == 3);
			texel_addr_q.push_back(r);
		end
	endfunction

	function automatic logic [31:0] random_derivative(input int sh);
		logic [31:0] d;
		d = {1'b1, 31'($urandom)} >> sh;
		if ($urandom_range(0, 3) == 0)
			d = d >> $urandom_range(0, 2);
		return d;
	endfunction

	function automatic quad_t random_quad();
		quad_t q;
		int    mode;
		int    sh;
		mode = $urandom_range(0, 9);
		sh = $urandom_range(0, 31);
		q.lane0_uv = $urandom;
		q.lane1_uv = $urandom;
		q.lane2_uv = $urandom;
		q.lane3_uv = $urandom;
		if ($urandom_range(0, 15) == 0)
			q.lane2_uv = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		if (mode < 2) begin
			q.lane0_footprint = {$urandom, $urandom};
			q.lane1_footprint = {$urandom, $urandom};
			q.lane2_footprint = {$urandom, $urandom};
			q.lane3_footprint = {$urandom, $urandom};
		end else begin
			q.lane0_footprint = {random_derivative(sh), random_derivative(sh)};
			q.lane1_footprint = {random_derivative(sh), random_derivative(sh)};
			q.lane2_footprint = {random_derivative(sh), random_derivative(sh)};
			q.lane3_footprint = {random_derivative(sh), random_derivative(sh)};
			if (mode == 9)
				q.lane1_footprint[31:0] = 32'd0;
		end
		q.use_mips = ($urandom_range(0, 7) != 0);
		return q;
	endfunction

	function automatic quad_t uniform_quad(input logic [31:0] uv, input logic [63:0] fp,
			input logic use_mips);
		quad_t q;
		q.lane0_uv = uv;
		q.lane1_uv = uv;
		q.lane2_uv = uv;
		q.lane3_uv = uv;
		q.lane0_footprint = fp;
		q.lane1_footprint = fp;
		q.lane2_footprint = fp;
		q.lane3_footprint = fp;
		q.use_mips = use_mips;
		return q;
	endfunction

	task automatic send_quad(input quad_t q);
		int gap;
		gap = sender_pauses ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			@(negedge clk);
			quad_bus.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		quad_bus.data  <= q;
		quad_bus.valid <= 1'b1;
		do @(posedge clk); while (!quad_bus.ready);
		compute_texel_addresses(q);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		quad_bus.valid <= 1'b0;
		while (texel_addr_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WIDTH_LOG2:  cfg_width_log2  = value[4:0];
			REG_HEIGHT_LOG2: cfg_height_log2 = value[4:0];
			REG_MIP_COUNT:   cfg_mip_count   = value[4:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_reg(input logic [1:0] idx, input logic [4:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {27'd0, want})
			note_error($sformatf("register %0d read: expected %h, got %h",
				idx, {27'd0, want}, prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_all_regs();
		check_reg(REG_WIDTH_LOG2, cfg_width_log2);
		check_reg(REG_HEIGHT_LOG2, cfg_height_log2);
		check_reg(REG_MIP_COUNT, cfg_mip_count);
	endtask

	task automatic configure(input logic [4:0] wl, input logic [4:0] hl,
			input logic [4:0] mc);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(REG_WIDTH_LOG2, {junk[31:5], wl});
		junk = $urandom;
		write_reg(REG_HEIGHT_LOG2, {junk[31:5], hl});
		junk = $urandom;
		write_reg(REG_MIP_COUNT, {junk[31:5], mc});
		check_all_regs();
	endtask

	task automatic test_coordinate_extremes();
		check_all_regs();
		send_quad(uniform_quad(32'h0000_0000, 64'd0, 1'b0));
		send_quad(uniform_quad(32'hFFFF_FFFF, '1, 1'b1));
		send_quad(uniform_quad(32'hFFFF_0000, 64'h0001_0000_0001_0000, 1'b1));
		send_quad(uniform_quad(32'h0000_FFFF, 64'h0000_0001_0000_0001, 1'b0));
		send_quad(uniform_quad(32'h8000_8000, 64'h0000_8000_0000_8000, 1'b1));
		send_quad(uniform_quad(32'h0001_0001, 64'h0100_0000_0100_0000, 1'b1));
	endtask

	task automatic test_mip_selection();
		quad_t q;
		wait_idle();
		configure(5'd8, 5'd8, 5'd16);
		send_quad(uniform_quad($urandom, 64'd0, 1'b1));
		send_quad(uniform_quad($urandom, '1, 1'b1));
		send_quad(uniform_quad($urandom, '1, 1'b0));
		for (int k = 10; k <= 31; k += 7)
			send_quad(uniform_quad($urandom, {32'd1 << k, 32'd1 << k}, 1'b1));
		q = uniform_quad($urandom, {32'h0100_0000, 32'h0100_0000}, 1'b1);
		q.lane2_footprint = {32'h0100_0000, 32'h0000_4000};
		send_quad(q);
		q.lane2_footprint = {32'h0000_0800, 32'hFFFF_FFFF};
		send_quad(q);
	endtask

	task automatic test_register_saturation();
		wait_idle();
		configure(5'd31, 5'd31, 5'd31);
		send_quad(uniform_quad(32'hFFFF_FFFF, '1, 1'b1));
		send_quad(random_quad());
		wait_idle();
		configure(5'd0, 5'd0, 5'd0);
		send_quad(uniform_quad(32'hFFFF_FFFF, '1, 1'b1));
		send_quad(random_quad());
		wait_idle();
		configure(5'd16, 5'd0, 5'd17);
		send_quad(uniform_quad(32'hFFFF_FFFF, 64'h0000_0100_FFFF_FFFF, 1'b1));
		send_quad(random_quad());
	endtask

	task automatic test_unknown_register();
		wait_idle();
		configure(5'd4, 5'd12, 5'd9);
		write_reg(REG_UNUSED, $urandom);
		check_all_regs();
		send_quad(random_quad());
	endtask

	task automatic test_back_pressure();
		wait_idle();
		configure(5'd12, 5'd10, 5'd9);
		@(negedge clk);
		sender_pauses   = 1'b0;
		receiver_pauses = 1'b0;
		hold_off_cycles = HOLD_CYCLES;
		for (int i = 0; i < 30; i++)
			send_quad(random_quad());
	endtask

	task automatic test_random_quads();
		logic [4:0] wl, hl, mc;
		for (int phase = 0; phase < 6; phase++) begin
			wait_idle();
			wl = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31)) :
				5'($urandom_range(0, 16));
			hl = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31)) :
				5'($urandom_range(0, 16));
			mc = 5'($urandom_range(0, 31));
			configure(wl, hl, mc);
			for (int i = 0; i < 70; i++) begin
				if (i % 35 == 0) begin
					@(negedge clk);
					sender_pauses   = ($urandom_range(0, 3) != 0);
					receiver_pauses = ($urandom_range(0, 3) != 0);
				end
				send_quad(random_quad());
			end
		end
	endtask

	initial begin
		int gap;
		result_bus.ready = 1'b0;
		forever begin
			gap = (hold_off_cycles > 0) ? hold_off_cycles :
				(receiver_pauses ? $urandom_range(0, 4) : 0);
			hold_off_cycles = 0;
			if (gap > 0) begin
				@(negedge clk);
				result_bus.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			result_bus.ready <= 1'b1;
			do @(posedge clk);
			while (!(result_bus.valid && result_bus.ready) && hold_off_cycles == 0);
		end
	end

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got = result_bus.data;
			if (texel_addr_q.size() == 0) begin
				note_error($sformatf("unexpected result transfer: %p", got));
			end else begin
				want = texel_addr_q.pop_front();
				if (got.lane_index !== want.lane_index || got.mip_level !== want.mip_level ||
						got.col_first !== want.col_first ||
						got.col_second !== want.col_second ||
						got.row_first !== want.row_first ||
						got.row_second !== want.row_second ||
						got.frac_x !== want.frac_x || got.frac_y !== want.frac_y ||
						got.last !== want.last)
					note_error($sformatf({"result mismatch\n  expected %p\n  actual   %p"},
						want, got));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** bilinear_texel_address_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		quad_bus.valid  = 1'b0;
		quad_bus.data   = '0;
		cfg_width_log2  = 5'd8;
		cfg_height_log2 = 5'd8;
		cfg_mip_count   = 5'd1;
		error_count     = 0;
		cycle_count     = 0;
		sender_pauses   = 1'b1;
		receiver_pauses = 1'b1;
		hold_off_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_coordinate_extremes();
		test_mip_selection();
		test_register_saturation();
		test_unknown_register();
		test_back_pressure();
		test_random_quads();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("** bilinear_texel_address_unit: PASSED **");
		else
			$display("** bilinear_texel_address_unit: FAILED **");
		$finish;
	end

endmodule
